>>> hw/rtl/nearest_upsample_3d_x2_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nearest_upsample_3d_x2 block
// Each macro names its label, clock and active-low reset, then the property.
// ----------------------------------------------------------------------------
`ifndef NEAREST_UPSAMPLE_3D_X2_MACROS_SVH
`define NEAREST_UPSAMPLE_3D_X2_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define NUS3_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nearest_upsample_3d_x2: same-cycle check failed");

// Next-cycle implication.
`define NUS3_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nearest_upsample_3d_x2: next-cycle check failed");

`else

`define NUS3_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define NUS3_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/nus3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nus3_pkg
// Shared constants and types of the 3D nearest-neighbor x2 upsampler.
// ----------------------------------------------------------------------------
package nus3_pkg;

    // Default sizing, handed to the top-level parameters.
    localparam int DEF_MAX_CHANNELS = 1024;
    localparam int DEF_MAX_EXTENT   = 2048;
    localparam int DEF_INDEX_WIDTH  = 32;

    // Fixed field widths.
    localparam int SAMPLE_W    = 32;
    localparam int DEST_W      = 32;
    localparam int CHAN_REG_W  = 11;
    localparam int EXT_REG_W   = 12;
    localparam int BATCH_REG_W = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] t_cfg_index;

    localparam t_cfg_index REG_CHANNEL_COUNT = 3'd0;
    localparam t_cfg_index REG_IN_WIDTH      = 3'd1;
    localparam t_cfg_index REG_IN_HEIGHT     = 3'd2;
    localparam t_cfg_index REG_IN_DEPTH      = 3'd3;
    localparam t_cfg_index REG_BATCH_COUNT   = 3'd4;

    // Entries in the queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Width of the copy counter; eight copies are emitted per input element.
    localparam int COPY_W = 3;

endpackage

>>> hw/rtl/nus3_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nus3_queue
// Small FIFO that decouples the front from the back.
// ----------------------------------------------------------------------------
module nus3_queue
    import nus3_pkg::*;
#(
    parameter int DATA_W = 65
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  logic [DATA_W-1:0] i_push_data,
    output logic              o_pop_valid,
    input  logic              i_pop_ready,
    output logic [DATA_W-1:0] o_pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              push_fire;
    logic              pop_fire;

    assign o_push_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push_fire    = i_push_valid && o_push_ready;
    assign pop_fire     = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push_fire) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_fire) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (pop_fire) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (push_fire && !pop_fire) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop_fire && !push_fire) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

>>> hw/rtl/nus3_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nus3_front
// Holds configuration and position counters, derives the strides, and turns
// each accepted element into its corner index for the back end.
// ----------------------------------------------------------------------------
module nus3_front
    import nus3_pkg::*;
#(
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    parameter int MAX_EXTENT   = DEF_MAX_EXTENT,
    parameter int INDEX_WIDTH  = DEF_INDEX_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [SAMPLE_W-1:0]    i_sample_bits,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  t_cfg_index             i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output logic                   o_push_valid,
    input  logic                   i_push_ready,
    output logic [INDEX_WIDTH-1:0] o_push_corner,
    output logic [SAMPLE_W-1:0]    o_push_bits,
    output logic                   o_push_last,
    output logic [INDEX_WIDTH-1:0] o_chan_stride,
    output logic [INDEX_WIDTH-1:0] o_row_delta,
    output logic [INDEX_WIDTH-1:0] o_plane_delta
);

    localparam int IW      = INDEX_WIDTH;
    localparam int CHAN_PW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int EXT_PW  = (MAX_EXTENT > 1) ? $clog2(MAX_EXTENT) : 1;
    localparam int SB_W    = EXT_REG_W + 1;
    localparam int SU_MW   = IW + SB_W;
    localparam int PX_MW   = IW + EXT_PW + 1;
    localparam int CMP_W   = 17;

    // Stride setup sequencer.
    localparam logic [2:0] SU_COW   = 3'd0;
    localparam logic [2:0] SU_COWOH = 3'd1;
    localparam logic [2:0] SU_BSTEP = 3'd2;
    localparam logic [2:0] SU_DELTA = 3'd3;
    localparam logic [2:0] SU_DONE  = 3'd4;

    logic [CHAN_REG_W-1:0]  r_channel_count;
    logic [EXT_REG_W-1:0]   r_in_width;
    logic [EXT_REG_W-1:0]   r_in_height;
    logic [EXT_REG_W-1:0]   r_in_depth;
    logic [BATCH_REG_W-1:0] r_batch_count;

    logic [CHAN_REG_W-1:0]  c_lim;
    logic [EXT_REG_W-1:0]   w_lim;
    logic [EXT_REG_W-1:0]   h_lim;
    logic [EXT_REG_W-1:0]   d_lim;
    logic [BATCH_REG_W-1:0] b_lim;
    logic [IW-1:0]          c_ext;

    logic [2:0]    r_su_state;
    logic [2:0]    n_su_state;
    logic [IW-1:0] su_a;
    logic [SB_W-1:0] su_b;
    logic [SU_MW-1:0] su_prod;
    logic [IW-1:0] r_cow;
    logic [IW-1:0] r_cowoh;
    logic [IW-1:0] r_bstep;
    logic [IW-1:0] r_row_delta;
    logic [IW-1:0] r_plane_delta;

    logic [CHAN_PW-1:0]     r_chan_pos;
    logic [EXT_PW-1:0]      r_x_pos;
    logic [EXT_PW-1:0]      r_y_pos;
    logic [EXT_PW-1:0]      r_z_pos;
    logic [BATCH_REG_W-1:0] r_batch_pos;
    logic [IW-1:0]          r_batch_base;
    logic [CHAN_PW-1:0]     n_chan_pos;
    logic [EXT_PW-1:0]      n_x_pos;
    logic [EXT_PW-1:0]      n_y_pos;
    logic [EXT_PW-1:0]      n_z_pos;
    logic [BATCH_REG_W-1:0] n_batch_pos;
    logic [IW-1:0]          n_batch_base;

    logic chan_wrap;
    logic x_wrap;
    logic y_wrap;
    logic z_wrap;
    logic batch_wrap;
    logic accept;
    logic push_fire;

    logic [PX_MW-1:0] prod_x;
    logic [PX_MW-1:0] prod_y;
    logic [PX_MW-1:0] prod_z;

    logic                r_s1_valid;
    logic [IW-1:0]       r_s1_tx;
    logic [IW-1:0]       r_s1_ty;
    logic [IW-1:0]       r_s1_tz;
    logic [IW-1:0]       r_s1_base;
    logic [IW-1:0]       r_s1_chan;
    logic [SAMPLE_W-1:0] r_s1_bits;
    logic                r_s1_last;

    // Limits: zero acts as one; channel and extent values clamp to the max.
    always_comb begin
        if (r_channel_count == '0) begin
            c_lim = CHAN_REG_W'(1);
        end else if (32'(r_channel_count) > 32'(MAX_CHANNELS)) begin
            c_lim = CHAN_REG_W'(MAX_CHANNELS);
        end else begin
            c_lim = r_channel_count;
        end
        if (r_in_width == '0) begin
            w_lim = EXT_REG_W'(1);
        end else if (32'(r_in_width) > 32'(MAX_EXTENT)) begin
            w_lim = EXT_REG_W'(MAX_EXTENT);
        end else begin
            w_lim = r_in_width;
        end
        if (r_in_height == '0) begin
            h_lim = EXT_REG_W'(1);
        end else if (32'(r_in_height) > 32'(MAX_EXTENT)) begin
            h_lim = EXT_REG_W'(MAX_EXTENT);
        end else begin
            h_lim = r_in_height;
        end
        if (r_in_depth == '0) begin
            d_lim = EXT_REG_W'(1);
        end else if (32'(r_in_depth) > 32'(MAX_EXTENT)) begin
            d_lim = EXT_REG_W'(MAX_EXTENT);
        end else begin
            d_lim = r_in_depth;
        end
        b_lim = (r_batch_count == '0) ? BATCH_REG_W'(1) : r_batch_count;
    end

    assign c_ext = IW'(c_lim);

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= CHAN_REG_W'(1);
            r_in_width      <= EXT_REG_W'(1);
            r_in_height     <= EXT_REG_W'(1);
            r_in_depth      <= EXT_REG_W'(1);
            r_batch_count   <= BATCH_REG_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[CHAN_REG_W-1:0];
                REG_IN_WIDTH:      r_in_width      <= i_cfg_data[EXT_REG_W-1:0];
                REG_IN_HEIGHT:     r_in_height     <= i_cfg_data[EXT_REG_W-1:0];
                REG_IN_DEPTH:      r_in_depth      <= i_cfg_data[EXT_REG_W-1:0];
                REG_BATCH_COUNT:   r_batch_count   <= i_cfg_data[BATCH_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // One shared multiplier builds the strides after reset and after any write.
    always_comb begin
        su_a       = c_ext;
        su_b       = {w_lim, 1'b0};
        n_su_state = r_su_state;
        unique case (r_su_state)
            SU_COW: begin
                su_a       = c_ext;
                su_b       = {w_lim, 1'b0};
                n_su_state = SU_COWOH;
            end
            SU_COWOH: begin
                su_a       = r_cow;
                su_b       = {h_lim, 1'b0};
                n_su_state = SU_BSTEP;
            end
            SU_BSTEP: begin
                su_a       = r_cowoh;
                su_b       = {d_lim, 1'b0};
                n_su_state = SU_DELTA;
            end
            SU_DELTA: n_su_state = SU_DONE;
            SU_DONE:  n_su_state = SU_DONE;
            default:  n_su_state = SU_COW;
        endcase
        if (i_cfg_valid) begin
            n_su_state = SU_COW;
        end
    end

    assign su_prod = SU_MW'(su_a) * SU_MW'(su_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_su_state <= SU_COW;
        end else begin
            r_su_state <= n_su_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_su_state)
            SU_COW:   r_cow   <= su_prod[IW-1:0];
            SU_COWOH: r_cowoh <= su_prod[IW-1:0];
            SU_BSTEP: r_bstep <= su_prod[IW-1:0];
            SU_DELTA: begin
                r_row_delta   <= r_cow - c_ext;
                r_plane_delta <= r_cowoh - r_cow - c_ext;
            end
            default: ;
        endcase
    end

    assign o_chan_stride = c_ext;
    assign o_row_delta   = r_row_delta;
    assign o_plane_delta = r_plane_delta;

    // Input handshake.
    assign push_fire = r_s1_valid && i_push_ready;
    assign o_stall   = (r_su_state != SU_DONE) || (r_s1_valid && !i_push_ready);
    assign accept    = i_valid && !o_stall;

    // A counter at or beyond its limit minus one wraps and carries.
    assign chan_wrap  = CMP_W'(r_chan_pos)  >= CMP_W'(c_lim) - CMP_W'(1);
    assign x_wrap     = CMP_W'(r_x_pos)     >= CMP_W'(w_lim) - CMP_W'(1);
    assign y_wrap     = CMP_W'(r_y_pos)     >= CMP_W'(h_lim) - CMP_W'(1);
    assign z_wrap     = CMP_W'(r_z_pos)     >= CMP_W'(d_lim) - CMP_W'(1);
    assign batch_wrap = CMP_W'(r_batch_pos) >= CMP_W'(b_lim) - CMP_W'(1);

    always_comb begin
        n_chan_pos   = r_chan_pos;
        n_x_pos      = r_x_pos;
        n_y_pos      = r_y_pos;
        n_z_pos      = r_z_pos;
        n_batch_pos  = r_batch_pos;
        n_batch_base = r_batch_base;
        if (accept) begin
            n_chan_pos = chan_wrap ? '0 : r_chan_pos + CHAN_PW'(1);
            if (chan_wrap) begin
                n_x_pos = x_wrap ? '0 : r_x_pos + EXT_PW'(1);
                if (x_wrap) begin
                    n_y_pos = y_wrap ? '0 : r_y_pos + EXT_PW'(1);
                    if (y_wrap) begin
                        n_z_pos = z_wrap ? '0 : r_z_pos + EXT_PW'(1);
                        if (z_wrap) begin
                            if (batch_wrap) begin
                                n_batch_pos  = '0;
                                n_batch_base = '0;
                            end else begin
                                n_batch_pos  = r_batch_pos + BATCH_REG_W'(1);
                                n_batch_base = r_batch_base + r_bstep;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_pos   <= '0;
            r_x_pos      <= '0;
            r_y_pos      <= '0;
            r_z_pos      <= '0;
            r_batch_pos  <= '0;
            r_batch_base <= '0;
        end else begin
            r_chan_pos   <= n_chan_pos;
            r_x_pos      <= n_x_pos;
            r_y_pos      <= n_y_pos;
            r_z_pos      <= n_z_pos;
            r_batch_pos  <= n_batch_pos;
            r_batch_base <= n_batch_base;
        end
    end

    // Position terms of the corner index, one multiplier each.
    assign prod_x = PX_MW'(c_ext)   * PX_MW'({r_x_pos, 1'b0});
    assign prod_y = PX_MW'(r_cow)   * PX_MW'({r_y_pos, 1'b0});
    assign prod_z = PX_MW'(r_cowoh) * PX_MW'({r_z_pos, 1'b0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept || (r_s1_valid && !push_fire);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_tx   <= prod_x[IW-1:0];
            r_s1_ty   <= prod_y[IW-1:0];
            r_s1_tz   <= prod_z[IW-1:0];
            r_s1_base <= r_batch_base;
            r_s1_chan <= IW'(r_chan_pos);
            r_s1_bits <= i_sample_bits;
            r_s1_last <= chan_wrap && x_wrap && y_wrap && z_wrap && batch_wrap;
        end
    end

    assign o_push_valid  = r_s1_valid;
    assign o_push_corner = r_s1_base + r_s1_chan + r_s1_tx + r_s1_ty + r_s1_tz;
    assign o_push_bits   = r_s1_bits;
    assign o_push_last   = r_s1_last;

endmodule

>>> hw/rtl/nus3_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nus3_back
// Expands one queued corner into eight copy writes, one per unstalled cycle.
// ----------------------------------------------------------------------------
module nus3_back
    import nus3_pkg::*;
#(
    parameter int INDEX_WIDTH = DEF_INDEX_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_pop_valid,
    output logic                   o_pop_ready,
    input  logic [INDEX_WIDTH-1:0] i_corner,
    input  logic [SAMPLE_W-1:0]    i_bits,
    input  logic                   i_last,
    input  logic [INDEX_WIDTH-1:0] i_chan_stride,
    input  logic [INDEX_WIDTH-1:0] i_row_delta,
    input  logic [INDEX_WIDTH-1:0] i_plane_delta,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [DEST_W-1:0]      o_dest_index,
    output logic [SAMPLE_W-1:0]    o_dest_bits,
    output logic                   o_last_copy,
    output logic                   o_end_of_tensor
);

    localparam int IW = INDEX_WIDTH;
    localparam logic [COPY_W-1:0] FINAL_COPY = '1;
    localparam logic [COPY_W-1:0] PLANE_COPY = COPY_W'(3);

    logic                r_busy;
    logic [COPY_W-1:0]   r_copy;
    logic [IW-1:0]       r_idx;
    logic [SAMPLE_W-1:0] r_bits;
    logic                r_last;
    logic                r_out_valid;
    logic [IW-1:0]       r_out_idx;
    logic [SAMPLE_W-1:0] r_out_bits;
    logic                r_out_last_copy;
    logic                r_out_eot;
    logic                out_free;
    logic                emit;
    logic                pop_fire;
    logic [IW-1:0]       delta;

    assign out_free    = !r_out_valid || !i_stall;
    assign emit        = r_busy && out_free;
    assign o_pop_ready = !r_busy || (emit && (r_copy == FINAL_COPY));
    assign pop_fire    = i_pop_valid && o_pop_ready;

    // Copy order walks x, then y, then z; even steps move one voxel in x.
    always_comb begin
        if (!r_copy[0]) begin
            delta = i_chan_stride;
        end else if (r_copy == PLANE_COPY) begin
            delta = i_plane_delta;
        end else begin
            delta = i_row_delta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop_fire) begin
                r_busy <= 1'b1;
            end else if (emit && (r_copy == FINAL_COPY)) begin
                r_busy <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= r_busy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop_fire) begin
            r_copy <= '0;
            r_idx  <= i_corner;
            r_bits <= i_bits;
            r_last <= i_last;
        end else if (emit) begin
            r_copy <= r_copy + COPY_W'(1);
            r_idx  <= r_idx + delta;
        end
        if (emit) begin
            r_out_idx       <= r_idx;
            r_out_bits      <= r_bits;
            r_out_last_copy <= (r_copy == FINAL_COPY);
            r_out_eot       <= (r_copy == FINAL_COPY) && r_last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_dest_index    = DEST_W'(r_out_idx);
    assign o_dest_bits     = r_out_bits;
    assign o_last_copy     = r_out_last_copy;
    assign o_end_of_tensor = r_out_eot;

endmodule

>>> hw/rtl/nearest_upsample_3d_x2.sv
// The first copy of an element passes the front stage register, the queue, the back
// corner register and the output register. Copies go out at one copy per cycle while
// i_stall is low. Reset and every configuration write start a stride setup on one shared
// multiplier; input is stalled until it ends. Reset (i_rst_n low, synchronous) sets
// all registers to 1 and clears position counters, queue and output.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_upsample_3d_x2
// Nearest-neighbor 3D upsampling by two: each input element becomes eight
// output writes, each with the element value and the index of one copy.
// ----------------------------------------------------------------------------
`include "nearest_upsample_3d_x2_macros.svh"

module nearest_upsample_3d_x2
    import nus3_pkg::*;
#(
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    parameter int MAX_EXTENT   = DEF_MAX_EXTENT,
    parameter int INDEX_WIDTH  = DEF_INDEX_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input element channel.
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [SAMPLE_W-1:0]   i_sample_bits,
    // Configuration write channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  t_cfg_index            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Copy write channel.
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [DEST_W-1:0]     o_dest_index,
    output logic [SAMPLE_W-1:0]   o_dest_bits,
    output logic                  o_last_copy,
    output logic                  o_end_of_tensor
);

    // A queue entry carries the corner index, the element bits and the
    // end-of-tensor mark of one element.
    localparam int Q_DATA_W = INDEX_WIDTH + SAMPLE_W + 1;

    logic                   push_valid;
    logic                   push_ready;
    logic [INDEX_WIDTH-1:0] push_corner;
    logic [SAMPLE_W-1:0]    push_bits;
    logic                   push_last;
    logic                   pop_valid;
    logic                   pop_ready;
    logic [Q_DATA_W-1:0]    pop_data;
    logic [INDEX_WIDTH-1:0] chan_stride;
    logic [INDEX_WIDTH-1:0] row_delta;
    logic [INDEX_WIDTH-1:0] plane_delta;

    // The front takes one element per transfer, advances the position
    // counters and registers the position products in one stage; the corner
    // index is summed from that stage on its way into the queue.
    nus3_front #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_EXTENT   (MAX_EXTENT),
        .INDEX_WIDTH  (INDEX_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_sample_bits (i_sample_bits),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_push_valid  (push_valid),
        .i_push_ready  (push_ready),
        .o_push_corner (push_corner),
        .o_push_bits   (push_bits),
        .o_push_last   (push_last),
        .o_chan_stride (chan_stride),
        .o_row_delta   (row_delta),
        .o_plane_delta (plane_delta)
    );

    // The queue lets the front keep taking elements while the back is still
    // emitting the copies of earlier ones.
    nus3_queue #(
        .DATA_W (Q_DATA_W)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  ({push_corner, push_bits, push_last}),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    // The back walks the eight corners with one adder and an output register.
    nus3_back #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_pop_valid     (pop_valid),
        .o_pop_ready     (pop_ready),
        .i_corner        (pop_data[Q_DATA_W-1 -: INDEX_WIDTH]),
        .i_bits          (pop_data[SAMPLE_W:1]),
        .i_last          (pop_data[0]),
        .i_chan_stride   (chan_stride),
        .i_row_delta     (row_delta),
        .i_plane_delta   (plane_delta),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_dest_index    (o_dest_index),
        .o_dest_bits     (o_dest_bits),
        .o_last_copy     (o_last_copy),
        .o_end_of_tensor (o_end_of_tensor)
    );

    // The end of the tensor is only ever flagged on the last copy of an element.
    `NUS3_ASSERT_NOW(a_eot_on_last, i_clk, i_rst_n, o_valid && o_end_of_tensor, o_last_copy)
    // Copies of one element follow without a gap once the previous one is taken.
    `NUS3_ASSERT_NEXT(a_copies_gapless, i_clk, i_rst_n, o_valid && !i_stall && !o_last_copy, o_valid)
    // All eight copies of an element carry the same bits.
    `NUS3_ASSERT_NEXT(a_copy_bits_same, i_clk, i_rst_n, o_valid && !i_stall && !o_last_copy, o_dest_bits == $past(o_dest_bits))
    // A configuration write restarts stride setup, so input is held off next cycle.
    `NUS3_ASSERT_NEXT(a_cfg_holds_input, i_clk, i_rst_n, i_cfg_valid && o_cfg_ready, o_stall)

endmodule

>>> dv/tb_nearest_upsample_3d_x2.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_upsample_3d_x2
// Self-checking bench for the 3D nearest-neighbor x2 upsampler. A table of
// directed elements and register writes runs first, then randomized
// configurations with random element data. Every element is run through a
// local model of the position counters and copy indices, and each copy
// transfer on the output is checked field by field against the oldest
// expected copy.
// ----------------------------------------------------------------------------
module tb_nearest_upsample_3d_x2
    import nus3_pkg::*;
();

    // The block always emits eight copies per element.
    localparam int COPIES = 8;
    // Run length and flow-control shaping.
    localparam int TOTAL_ELEMENTS = 460;
    localparam int HOLD_AT        = 400;
    localparam int HOLD_CYCLES    = 300;
    // Elements still offered after the long receiver hold begins.
    localparam int HOLD_TAIL      = 24;
    // Quiet margin covering the output pipeline and the stride setup after a write.
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam bit [63:0] INDEX_MASK = (64'd1 << DEF_INDEX_WIDTH) - 64'd1;

    // One expected or observed copy write.
    typedef struct packed {
        logic [DEST_W-1:0]   dest_index;
        logic [SAMPLE_W-1:0] dest_bits;
        logic                last_copy;
        logic                end_of_tensor;
    } t_copy;

    // One row of the directed table: either a register write or an element.
    typedef enum logic {ROW_SAMPLE, ROW_WRITE} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        t_cfg_index            sel;
        logic [CFG_DATA_W-1:0] data;
        logic [SAMPLE_W-1:0]   bits;
        logic                  typed;
    } t_plan_row;

    // Rows marked typed run with every register at its reset value of 1, so the
    // eight copies land on indices 0..7 and every element ends the tensor.
    // The remaining rows are checked against the local model.
    localparam int PLAN_ROWS = 29;
    localparam t_plan_row PLAN [PLAN_ROWS] = '{
        '{ROW_SAMPLE, REG_CHANNEL_COUNT, 16'h0000, 32'h0000_0000, 1'b1},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT, 16'h0000, 32'hFFFF_FFFF, 1'b1},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT, 16'h0000, 32'h5555_5555, 1'b1},
        // Zero registers act as one, and bits above a register's width are dropped.
        '{ROW_WRITE,  REG_CHANNEL_COUNT, 16'hF800, 32'h0,         1'b0},
        '{ROW_WRITE,  REG_IN_WIDTH,      16'h0002, 32'h0,         1'b0},
        '{ROW_WRITE,  REG_IN_HEIGHT,     16'h0000, 32'h0,         1'b0},
        '{ROW_WRITE,  REG_IN_DEPTH,      16'hF002, 32'h0,         1'b0},
        '{ROW_WRITE,  REG_BATCH_COUNT,   16'h0002, 32'h0,         1'b0},
        // Two batches of 2x1x2 voxels: eight elements, then a fresh tensor.
        '{ROW_SAMPLE, REG_CHANNEL_COUNT, 16'h0000, 32'hAAAA_AAAA, 1'b0},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT, 16'h0000, 32'h1234_5678, 1'b0},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT, 16'h0000, 32'h0F0F_0F0F, 1'b0},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT, 16'h0000, 32'hF0F0_F0F0, 1'b0},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT, 16'h0000, 32'h8000_0000, 1'b0},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT, 16'h0000, 32'h0000_0001, 1'b0},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT, 16'h0000, 32'hDEAD_BEEF, 1'b0},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT, 16'h0000, 32'h3C3C_3C3C, 1'b0},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT, 16'h0000, 32'hC001_D00D, 1'b0},
        // Registers above range clamp to the maximum; copy offsets wrap the index.
        '{ROW_WRITE,  REG_CHANNEL_COUNT, 16'h07FF, 32'h0,         1'b0},
        '{ROW_WRITE,  REG_IN_WIDTH,      16'hFFFF, 32'h0,         1'b0},
        '{ROW_WRITE,  REG_IN_HEIGHT,     16'h0FFF, 32'h0,         1'b0},
        '{ROW_WRITE,  REG_IN_DEPTH,      16'h0800, 32'h0,         1'b0},
        '{ROW_WRITE,  REG_BATCH_COUNT,   16'hFFFF, 32'h0,         1'b0},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT, 16'h0000, 32'h0000_0000, 1'b0},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT, 16'h0000, 32'hFFFF_FFFF, 1'b0},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT, 16'h0000, 32'h8000_0001, 1'b0},
        // Shrinking the channel count down to the running channel position
        // forces a wrap with carry on the next element.
        '{ROW_WRITE,  REG_CHANNEL_COUNT, 16'h0003, 32'h0,         1'b0},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT, 16'h0000, 32'h7FFF_FFFF, 1'b0},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT, 16'h0000, 32'h0000_0001, 1'b0},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT, 16'h0000, 32'hFEDC_BA98, 1'b0}
    };

    // Clock, reset and every block input start at a known value.
    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_valid       = 1'b0;
    logic [SAMPLE_W-1:0]   i_sample_bits = '0;
    logic                  i_cfg_valid   = 1'b0;
    t_cfg_index            i_cfg_index   = REG_CHANNEL_COUNT;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  i_stall       = 1'b0;
    logic                  o_stall;
    logic                  o_cfg_ready;
    logic                  o_valid;
    logic [DEST_W-1:0]     o_dest_index;
    logic [SAMPLE_W-1:0]   o_dest_bits;
    logic                  o_last_copy;
    logic                  o_end_of_tensor;

    nearest_upsample_3d_x2 dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_sample_bits   (i_sample_bits),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_dest_index    (o_dest_index),
        .o_dest_bits     (o_dest_bits),
        .o_last_copy     (o_last_copy),
        .o_end_of_tensor (o_end_of_tensor)
    );

    // Shadow copies of the registers and position counters of the block.
    logic [CHAN_REG_W-1:0]  chan_reg   = 1;
    logic [EXT_REG_W-1:0]   width_reg  = 1;
    logic [EXT_REG_W-1:0]   height_reg = 1;
    logic [EXT_REG_W-1:0]   depth_reg  = 1;
    logic [BATCH_REG_W-1:0] batch_reg  = 1;
    bit [63:0] chan_at, x_at, y_at, z_at, batch_at, batch_offset;

    // Copies predicted but not yet seen on the output, oldest first.
    t_copy pending_copies [$];

    int unsigned elements_sent  = 0;
    int unsigned copies_checked = 0;
    int unsigned tensors_seen   = 0;
    int unsigned cfg_writes     = 0;
    int unsigned mismatches     = 0;
    int unsigned send_idle_pct  = 17;
    int unsigned recv_idle_pct  = 86;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // A zero register means one, anything above the maximum means the maximum.
    function automatic bit [63:0] clamp_limit(input bit [63:0] value, input bit [63:0] hi);
        if (value == 0) return 1;
        if (value > hi) return hi;
        return value;
    endfunction

    // Step a position counter; returns 1 when it wraps and carries onward.
    function automatic bit bump(inout bit [63:0] pos, input bit [63:0] lim);
        if (pos >= lim - 1) begin
            pos = 0;
            return 1'b1;
        end
        pos = pos + 1;
        return 1'b0;
    endfunction

    // Works out the eight copies of one element and advances the counters.
    function automatic void upsample_element(input logic [SAMPLE_W-1:0] bits,
                                             output t_copy copies [COPIES]);
        bit [63:0] c, w, h, d, b, ow, oh, corner;
        bit [63:0] offs [COPIES];
        bit        last_elem;
        c  = clamp_limit(chan_reg, DEF_MAX_CHANNELS);
        w  = clamp_limit(width_reg, DEF_MAX_EXTENT);
        h  = clamp_limit(height_reg, DEF_MAX_EXTENT);
        d  = clamp_limit(depth_reg, DEF_MAX_EXTENT);
        b  = clamp_limit(batch_reg, 64'hFFFF);
        ow = 2 * w;
        oh = 2 * h;

        // Corner order: same row, next x, next y, next x and y; then the same
        // four one output plane further in z.
        offs[0] = 0;
        offs[1] = c;
        offs[2] = (c * ow) & INDEX_MASK;
        offs[3] = (c * (ow + 1)) & INDEX_MASK;
        for (int k = 0; k < 4; k++)
            offs[k + 4] = (offs[k] + c * ow * oh) & INDEX_MASK;

        corner = (2 * x_at + ow * ((2 * y_at + oh * (2 * z_at)) & INDEX_MASK)) & INDEX_MASK;
        corner = (batch_offset + c * corner + chan_at) & INDEX_MASK;

        last_elem = chan_at >= c - 1 && x_at >= w - 1 && y_at >= h - 1 &&
                    z_at >= d - 1 && batch_at >= b - 1;

        for (int k = 0; k < COPIES; k++) begin
            copies[k].dest_index    = DEST_W'((corner + offs[k]) & INDEX_MASK);
            copies[k].dest_bits     = bits;
            copies[k].last_copy     = (k == COPIES - 1);
            copies[k].end_of_tensor = (k == COPIES - 1) && last_elem;
        end

        if (bump(chan_at, c)) begin
            if (bump(x_at, w)) begin
                if (bump(y_at, h)) begin
                    if (bump(z_at, d)) begin
                        if (bump(batch_at, b))
                            batch_offset = 0;
                        else
                            batch_offset = (batch_offset + 8 * c * w * h * d) & INDEX_MASK;
                    end
                end
            end
        end
    endfunction

    // Random register value: mostly small, sometimes zero, sometimes anything.
    // Bits above the register's width carry noise that the block must drop.
    function automatic logic [CFG_DATA_W-1:0] pick_reg_value(input int width,
                                                             input int typical_hi);
        logic [CFG_DATA_W-1:0] keep, value;
        int unsigned           roll;
        keep = 16'hFFFF >> (CFG_DATA_W - width);
        roll = $urandom_range(19);
        if (roll == 0)
            value = '0;
        else if (roll == 1)
            value = CFG_DATA_W'($urandom) & keep;
        else
            value = CFG_DATA_W'($urandom_range(typical_hi, 1));
        return value | (CFG_DATA_W'($urandom) & ~keep);
    endfunction

    // Offers one element and holds it until the transfer. The valid line is
    // left high so a following element can go out on the next cycle.
    task automatic send_sample(input logic [SAMPLE_W-1:0] bits, input logic typed);
        t_copy made [COPIES];
        // Flow-control mode: sender mostly busy and receiver mostly stalled,
        // then the reverse, then both running flat out.
        if (elements_sent < 160) begin
            send_idle_pct = 17;
            recv_idle_pct = 86;
        end else if (elements_sent < 320) begin
            send_idle_pct = 86;
            recv_idle_pct = 17;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_sample_bits <= bits;
        do @(posedge i_clk); while (o_stall);

        upsample_element(bits, made);
        for (int k = 0; k < COPIES; k++) begin
            if (typed)
                pending_copies.push_back('{dest_index: DEST_W'(k), dest_bits: bits,
                                           last_copy: (k == COPIES - 1),
                                           end_of_tensor: (k == COPIES - 1)});
            else
                pending_copies.push_back(made[k]);
        end
        elements_sent++;
    endtask

    // One register write transfer; the valid line stays high for the caller.
    task automatic write_reg(input t_cfg_index sel, input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (sel)
            REG_CHANNEL_COUNT: chan_reg   = value[CHAN_REG_W-1:0];
            REG_IN_WIDTH:      width_reg  = value[EXT_REG_W-1:0];
            REG_IN_HEIGHT:     height_reg = value[EXT_REG_W-1:0];
            REG_IN_DEPTH:      depth_reg  = value[EXT_REG_W-1:0];
            REG_BATCH_COUNT:   batch_reg  = value[BATCH_REG_W-1:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    // Registers are only rewritten with the block empty: stop offering, wait
    // for every expected copy, then give the pipeline time to go quiet.
    task automatic settle_block();
        i_valid <= 1'b0;
        while (pending_copies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Stimulus: reset, the directed table, then random configurations.
    initial begin
        bit        writing;
        bit [63:0] tensor;
        int        count;
        writing = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < PLAN_ROWS; r++) begin
            if (PLAN[r].kind == ROW_WRITE) begin
                if (!writing) settle_block();
                writing = 1'b1;
                write_reg(PLAN[r].sel, PLAN[r].data);
            end else begin
                if (writing) i_cfg_valid <= 1'b0;
                writing = 1'b0;
                send_sample(PLAN[r].bits, PLAN[r].typed);
            end
        end

        // Each random phase rewrites some or all registers and then sends
        // mostly whole tensors, sometimes with a few extra elements so the next
        // phase reconfigures with the counters part way through a map.
        while (elements_sent < TOTAL_ELEMENTS) begin
            settle_block();
            if ($urandom_range(9) < 8)
                write_reg(REG_CHANNEL_COUNT, pick_reg_value(CHAN_REG_W, 4));
            if ($urandom_range(9) < 8)
                write_reg(REG_IN_WIDTH, pick_reg_value(EXT_REG_W, 3));
            if ($urandom_range(9) < 8)
                write_reg(REG_IN_HEIGHT, pick_reg_value(EXT_REG_W, 3));
            if ($urandom_range(9) < 8)
                write_reg(REG_IN_DEPTH, pick_reg_value(EXT_REG_W, 3));
            if ($urandom_range(9) < 8)
                write_reg(REG_BATCH_COUNT, pick_reg_value(BATCH_REG_W, 3));
            i_cfg_valid <= 1'b0;

            tensor = clamp_limit(chan_reg, DEF_MAX_CHANNELS) *
                     clamp_limit(width_reg, DEF_MAX_EXTENT) *
                     clamp_limit(height_reg, DEF_MAX_EXTENT) *
                     clamp_limit(depth_reg, DEF_MAX_EXTENT) *
                     clamp_limit(batch_reg, 64'hFFFF);
            if (tensor <= 40) begin
                count = int'(tensor) * $urandom_range(2, 1);
                if ($urandom_range(3) == 0) count += $urandom_range(3, 1);
            end else begin
                count = $urandom_range(30, 5);
            end
            // The phase that reaches the long receiver hold keeps offering
            // elements past it, so the block backs up into its input.
            if (elements_sent < HOLD_AT && int'(elements_sent) + count >= HOLD_AT)
                count += HOLD_TAIL;
            if (int'(elements_sent) + count > TOTAL_ELEMENTS)
                count = TOTAL_ELEMENTS - int'(elements_sent);
            repeat (count) send_sample($urandom, 1'b0);
        end

        // Drain: stop offering, wait for the last copies, then watch a little
        // longer for anything the block should not have sent.
        i_valid <= 1'b0;
        while (pending_copies.size() != 0) @(posedge i_clk);
        repeat (4 * SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d elements across %0d register writes; checked %0d copies,",
                 elements_sent, cfg_writes, copies_checked);
        $display("%0d of them closing a tensor, with %0d mismatches.",
                 tensors_seen, mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Output side: check every copy transfer against the oldest expectation,
    // then decide the stall for the next cycle. Once, late in the run, the
    // receiver stalls for a long stretch so the block backs up into its input.
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    always @(posedge i_clk) begin : copy_monitor
        t_copy want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_copies.size() == 0) begin
                $display("%0t: unexpected copy, index %h bits %h", $time,
                         o_dest_index, o_dest_bits);
                mismatches++;
            end else begin
                want = pending_copies.pop_front();
                if (o_dest_index !== want.dest_index) begin
                    $display("%0t: dest_index expected %h, got %h", $time,
                             want.dest_index, o_dest_index);
                    mismatches++;
                end
                if (o_dest_bits !== want.dest_bits) begin
                    $display("%0t: dest_bits expected %h, got %h", $time,
                             want.dest_bits, o_dest_bits);
                    mismatches++;
                end
                if (o_last_copy !== want.last_copy) begin
                    $display("%0t: last_copy expected %b, got %b", $time,
                             want.last_copy, o_last_copy);
                    mismatches++;
                end
                if (o_end_of_tensor !== want.end_of_tensor) begin
                    $display("%0t: end_of_tensor expected %b, got %b", $time,
                             want.end_of_tensor, o_end_of_tensor);
                    mismatches++;
                end
                copies_checked++;
                if (want.end_of_tensor) tensors_seen++;
            end
        end

        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (!hold_done && elements_sent >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog: any transfer on any channel resets the count of quiet cycles.
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d copies still expected",
                     $time, quiet_cycles, pending_copies.size());
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
